// ===== rtl/atpr_pkg.sv =====
// shared constants, types and the arctangent table of the tilt pitch/roll core
package atpr_pkg;

  // rotation count, clipped to the length of the arctangent table
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_LEN     = 24;
  localparam int unsigned CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  // square root of a 48-bit radicand, one result bit per stage
  localparam int unsigned SQRT_STEPS = 24;
  localparam int unsigned RAD_W      = 2 * SQRT_STEPS;
  localparam int unsigned STEP_W     = $clog2(ATAN_LEN);

  localparam int unsigned AXIS_W    = 16;
  localparam int unsigned SQ_W      = 31;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned ROT_W     = 28;
  localparam int unsigned ACC_W     = 25;
  localparam int unsigned ATAN_W    = 22;
  localparam int unsigned ANG_W     = 16;
  localparam int unsigned FRAC_BITS = 8;

  localparam logic [7:0] DEVICE_ID   = 8'hE5;
  localparam int         ANGLE_LIMIT = 23040;  // 90 degrees with 8 fraction bits

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef struct packed {
    logic zero_num;
    logic zero_den;
    logic neg;
  } atpr_case_t;

  typedef struct packed {
    logic       ok;
    atpr_case_t pitch;
    atpr_case_t roll;
  } atpr_flags_t;

  typedef struct packed {
    atpr_flags_t               flags;
    logic signed [AXIS_W-1:0]  num_p;
    logic signed [AXIS_W-1:0]  num_r;
  } atpr_side_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [RAD_W-1:0] root;
  } atpr_root_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ACC_W-1:0] acc;
  } atpr_rot_t;

endpackage

// ===== rtl/atpr_sqrt_stage.sv =====
// one bit of the pipelined integer square root, both angles side by side
module atpr_sqrt_stage import atpr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [STEP_W-1:0] step_i,
  input  logic              valid_i,
  input  atpr_side_t        side_i,
  input  atpr_root_t        pitch_i,
  input  atpr_root_t        roll_i,
  output logic              valid_o,
  output atpr_side_t        side_o,
  output atpr_root_t        pitch_o,
  output atpr_root_t        roll_o
);

  function automatic atpr_root_t root_step(input atpr_root_t cur,
                                           input logic [STEP_W-1:0] step);
    atpr_root_t       nxt;
    logic [RAD_W-1:0] bit_v;
    logic [RAD_W-1:0] trial;
    bit_v = {{(RAD_W-1){1'b0}}, 1'b1} << (int'(RAD_W) - 2 - 2 * int'(step));
    trial = cur.root + bit_v;
    if (cur.rad >= trial) begin
      nxt.rad  = cur.rad - trial;
      nxt.root = (cur.root >> 1) + bit_v;
    end else begin
      nxt.rad  = cur.rad;
      nxt.root = cur.root >> 1;
    end
    return nxt;
  endfunction

  logic       valid_q;
  atpr_side_t side_q;
  atpr_root_t pitch_d, pitch_q;
  atpr_root_t roll_d, roll_q;

  assign pitch_d = root_step(pitch_i, step_i);
  assign roll_d  = root_step(roll_i, step_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q  <= side_i;
      pitch_q <= pitch_d;
      roll_q  <= roll_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign pitch_o = pitch_q;
  assign roll_o  = roll_q;

endmodule

// ===== rtl/atpr_cordic_stage.sv =====
// one vectoring rotation of the angle pipeline, both angles side by side
module atpr_cordic_stage import atpr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [STEP_W-1:0] step_i,
  input  logic              valid_i,
  input  atpr_flags_t       flags_i,
  input  atpr_rot_t         pitch_i,
  input  atpr_rot_t         roll_i,
  output logic              valid_o,
  output atpr_flags_t       flags_o,
  output atpr_rot_t         pitch_o,
  output atpr_rot_t         roll_o
);

  function automatic atpr_rot_t rot_step(input atpr_rot_t cur,
                                         input logic [STEP_W-1:0] step);
    atpr_rot_t               nxt;
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] xs;
    logic signed [ROT_W-1:0] ys;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] ang;
    x   = cur.x;
    y   = cur.y;
    acc = cur.acc;
    xs  = x >>> step;
    ys  = y >>> step;
    ang = signed'({{(ACC_W-ATAN_W){1'b0}}, ATAN_TABLE[step]});
    if (y > 0) begin
      nxt.x   = x + ys;
      nxt.y   = y - xs;
      nxt.acc = acc + ang;
    end else begin
      nxt.x   = x - ys;
      nxt.y   = y + xs;
      nxt.acc = acc - ang;
    end
    return nxt;
  endfunction

  logic        valid_q;
  atpr_flags_t flags_q;
  atpr_rot_t   pitch_d, pitch_q;
  atpr_rot_t   roll_d, roll_q;

  assign pitch_d = rot_step(pitch_i, step_i);
  assign roll_d  = rot_step(roll_i, step_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q <= flags_i;
      pitch_q <= pitch_d;
      roll_q  <= roll_d;
    end
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;
  assign pitch_o = pitch_q;
  assign roll_o  = roll_q;

endmodule

// ===== rtl/accel_tilt_pitch_roll_core.sv =====
// top level of the tilt core: axis decode, squares, root and cordic chains, output buffer
//
// usage
//   input channel: in_valid_i / in_ready_o carries one raw sample per request: the
//   identification byte and the low and high byte of the x, y and z axes
//   output channel: out_valid_o / out_ready_i carries id_ok_o, pitch_deg_o and
//   roll_deg_o (signed degrees, 8 fraction bits, clipped to +-90)
//   throughput: one request per cycle, set by the fully unrolled pipeline, while
//   the skid register is empty; the pipeline has 3 front stages, 24 root stages
//   and 16 rotation stages, then the output register that drives out_valid_o
//   stall: a two-entry output buffer (output register plus skid register) sits
//   after the pipeline; while the receiver holds out_ready_i low the first result
//   waits in the output register, the next one drops into the skid register and
//   only then do in_ready_o and the whole pipeline freeze, losing nothing
//   in_ready_o is driven from a register, with no path from out_ready_i
//   reset: rst_ni clears every valid bit, also those of both buffer entries, so no
//   result is pending; no table or memory needs filling
//   a sample with a wrong identification byte gives id_ok_o low and both angles 0
module accel_tilt_pitch_roll_core import atpr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              device_id_i,
  input  logic [7:0]              x_low_i,
  input  logic [7:0]              x_high_i,
  input  logic [7:0]              y_low_i,
  input  logic [7:0]              y_high_i,
  input  logic [7:0]              z_low_i,
  input  logic [7:0]              z_high_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    id_ok_o,
  output logic signed [ANG_W-1:0] pitch_deg_o,
  output logic signed [ANG_W-1:0] roll_deg_o
);

  localparam int unsigned QW = ACC_W - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ANG_W-1:0] ANG_MAX    = ANG_W'(ANGLE_LIMIT);
  localparam logic signed [ANG_W-1:0] ANG_MIN    = -ANG_MAX;
  localparam logic signed [QW-1:0]    Q_MAX      = QW'(ANGLE_LIMIT);
  localparam logic signed [QW-1:0]    Q_MIN      = -Q_MAX;

  typedef struct packed {
    logic                    id_ok;
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] roll;
  } atpr_out_t;

  // whole pipeline moves together; it only halts once the skid entry is taken
  logic en;
  logic skid_valid_q, skid_valid_d;
  logic out_valid_q, out_valid_d;

  assign en         = ~skid_valid_q;
  assign in_ready_o = en;

  // ---------------------------------------------------------------------------
  // stage a: join the byte pairs, spot the special cases early
  // ---------------------------------------------------------------------------
  logic signed [AXIS_W-1:0] ax_d, ay_d, az_d;
  atpr_flags_t              flags_a_d;

  assign ax_d = {x_high_i, x_low_i};
  assign ay_d = {y_high_i, y_low_i};
  assign az_d = {z_high_i, z_low_i};

  always_comb begin
    flags_a_d.ok             = (device_id_i == DEVICE_ID);
    flags_a_d.pitch.zero_num = (ax_d == '0);
    flags_a_d.pitch.zero_den = (ay_d == '0) && (az_d == '0);
    flags_a_d.pitch.neg      = ax_d[AXIS_W-1];
    flags_a_d.roll.zero_num  = (ay_d == '0);
    flags_a_d.roll.zero_den  = (ax_d == '0) && (az_d == '0);
    flags_a_d.roll.neg       = ay_d[AXIS_W-1];
  end

  logic                     va_q;
  atpr_flags_t              flags_a_q;
  logic signed [AXIS_W-1:0] ax_a_q, ay_a_q, az_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flags_a_q <= flags_a_d;
      ax_a_q    <= ax_d;
      ay_a_q    <= ay_d;
      az_a_q    <= az_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: squares of the three axes, one multiplier each
  // ---------------------------------------------------------------------------
  logic signed [2*AXIS_W-1:0] px, py, pz;
  logic [SQ_W-1:0]            sqx_d, sqy_d, sqz_d;

  assign px    = ax_a_q * ax_a_q;
  assign py    = ay_a_q * ay_a_q;
  assign pz    = az_a_q * az_a_q;
  assign sqx_d = px[SQ_W-1:0];
  assign sqy_d = py[SQ_W-1:0];
  assign sqz_d = pz[SQ_W-1:0];

  logic                     vb_q;
  atpr_flags_t              flags_b_q;
  logic signed [AXIS_W-1:0] ax_b_q, ay_b_q;
  logic [SQ_W-1:0]          sqx_q, sqy_q, sqz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flags_b_q <= flags_a_q;
      ax_b_q    <= ax_a_q;
      ay_b_q    <= ay_a_q;
      sqx_q     <= sqx_d;
      sqy_q     <= sqy_d;
      sqz_q     <= sqz_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: sums of squares under each angle
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_p_d, sum_r_d;
  atpr_side_t       side_c_d;

  assign sum_p_d = SUM_W'(sqy_q) + SUM_W'(sqz_q);
  assign sum_r_d = SUM_W'(sqx_q) + SUM_W'(sqz_q);

  always_comb begin
    side_c_d.flags = flags_b_q;
    side_c_d.num_p = ax_b_q;
    side_c_d.num_r = ay_b_q;
  end

  logic             vc_q;
  atpr_side_t       side_c_q;
  logic [SUM_W-1:0] sum_p_q, sum_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_c_q <= side_c_d;
      sum_p_q  <= sum_p_d;
      sum_r_q  <= sum_r_d;
    end
  end

  // ---------------------------------------------------------------------------
  // square root chain: radicand is the sum with 16 extra fraction bits
  // ---------------------------------------------------------------------------
  logic       sq_vld  [SQRT_STEPS+1];
  atpr_side_t sq_side [SQRT_STEPS+1];
  atpr_root_t sq_p    [SQRT_STEPS+1];
  atpr_root_t sq_r    [SQRT_STEPS+1];

  always_comb begin
    sq_vld[0]     = vc_q;
    sq_side[0]    = side_c_q;
    sq_p[0].rad   = {sum_p_q, {(RAD_W-SUM_W){1'b0}}};
    sq_p[0].root  = '0;
    sq_r[0].rad   = {sum_r_q, {(RAD_W-SUM_W){1'b0}}};
    sq_r[0].root  = '0;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    atpr_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (STEP_W'(k)),
      .valid_i (sq_vld[k]),
      .side_i  (sq_side[k]),
      .pitch_i (sq_p[k]),
      .roll_i  (sq_r[k]),
      .valid_o (sq_vld[k+1]),
      .side_o  (sq_side[k+1]),
      .pitch_o (sq_p[k+1]),
      .roll_o  (sq_r[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // cordic chain: vector (root, numerator * 256) rotated onto the x axis
  // ---------------------------------------------------------------------------
  logic        cr_vld   [CORDIC_ITERS+1];
  atpr_flags_t cr_flags [CORDIC_ITERS+1];
  atpr_rot_t   cr_p     [CORDIC_ITERS+1];
  atpr_rot_t   cr_r     [CORDIC_ITERS+1];

  logic signed [AXIS_W-1:0] num_p, num_r;

  assign num_p = sq_side[SQRT_STEPS].num_p;
  assign num_r = sq_side[SQRT_STEPS].num_r;

  always_comb begin
    cr_vld[0]   = sq_vld[SQRT_STEPS];
    cr_flags[0] = sq_side[SQRT_STEPS].flags;
    cr_p[0].x   = signed'({{(ROT_W-SQRT_STEPS){1'b0}},
                           sq_p[SQRT_STEPS].root[SQRT_STEPS-1:0]});
    cr_p[0].y   = {{(ROT_W-AXIS_W-FRAC_BITS){num_p[AXIS_W-1]}}, num_p,
                   {FRAC_BITS{1'b0}}};
    cr_p[0].acc = '0;
    cr_r[0].x   = signed'({{(ROT_W-SQRT_STEPS){1'b0}},
                           sq_r[SQRT_STEPS].root[SQRT_STEPS-1:0]});
    cr_r[0].y   = {{(ROT_W-AXIS_W-FRAC_BITS){num_r[AXIS_W-1]}}, num_r,
                   {FRAC_BITS{1'b0}}};
    cr_r[0].acc = '0;
  end

  for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_cordic
    atpr_cordic_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (STEP_W'(k)),
      .valid_i (cr_vld[k]),
      .flags_i (cr_flags[k]),
      .pitch_i (cr_p[k]),
      .roll_i  (cr_r[k]),
      .valid_o (cr_vld[k+1]),
      .flags_o (cr_flags[k+1]),
      .pitch_o (cr_p[k+1]),
      .roll_o  (cr_r[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // rounding to 8 fraction bits, clipping, special cases
  // ---------------------------------------------------------------------------
  function automatic logic signed [ANG_W-1:0] finish_angle(
    input logic                    ok,
    input atpr_case_t              c,
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] biased;
    logic signed [QW-1:0]    q;
    logic signed [ANG_W-1:0] res;
    biased = acc + ROUND_BIAS;
    q      = biased[ACC_W-1:FRAC_BITS];   // floor division by 256
    priority if (!ok || c.zero_num) begin
      res = '0;
    end else if (c.zero_den) begin
      res = c.neg ? ANG_MIN : ANG_MAX;
    end else if (q > Q_MAX) begin
      res = ANG_MAX;
    end else if (q < Q_MIN) begin
      res = ANG_MIN;
    end else begin
      res = q[ANG_W-1:0];
    end
    return res;
  endfunction

  logic        fin_valid;
  atpr_out_t   fin_res;
  atpr_flags_t fin_flags;

  assign fin_flags = cr_flags[CORDIC_ITERS];
  assign fin_valid = cr_vld[CORDIC_ITERS] & en;

  always_comb begin
    fin_res.id_ok = fin_flags.ok;
    fin_res.pitch = finish_angle(fin_flags.ok, fin_flags.pitch, cr_p[CORDIC_ITERS].acc);
    fin_res.roll  = finish_angle(fin_flags.ok, fin_flags.roll, cr_r[CORDIC_ITERS].acc);
  end

  // ---------------------------------------------------------------------------
  // output register plus skid entry
  // ---------------------------------------------------------------------------
  atpr_out_t out_q, out_d;
  atpr_out_t skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        // skid entry moves up, pipeline restarts next cycle
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = fin_valid;
        out_d       = fin_res;
      end
    end else if (fin_valid) begin
      // receiver stalled: park the arriving result
      skid_valid_d = 1'b1;
      skid_d       = fin_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign id_ok_o     = out_q.id_ok;
  assign pitch_deg_o = out_q.pitch;
  assign roll_deg_o  = out_q.roll;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_bad_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !id_ok_o |-> pitch_deg_o == '0 && roll_deg_o == '0)
    else $error("wrong identification but nonzero angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pitch_deg_o <= ANG_MAX && pitch_deg_o >= ANG_MIN &&
                    roll_deg_o <= ANG_MAX && roll_deg_o >= ANG_MIN)
    else $error("angle beyond +-90 degrees");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_skid_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_ready_i |=> skid_valid_q && $stable(skid_q))
    else $error("skid entry lost during stall");

endmodule
